FILE: hdl/lfu_page_replacement_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LFU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfu_page_replacement: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfu_page_replacement: next-cycle check failed");

`endif

FILE: hdl/lfu_pr_pkg.sv
package lfu_pr_pkg;

    localparam int CFG_BITS = 4;
    localparam int FRAME_INDEX_BITS = 3;
    localparam int CTR_BITS = 32;
    localparam logic [CFG_BITS-1:0] FRAMES_USED_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_TOUCH,
        ST_TOUCH_END,
        ST_WRITE
    } eng_state_t;

    typedef struct packed {
        logic take_hit;
        logic take_empty;
        logic take_vic;
    } cmp_result_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic hit;
        logic evicted;
    } eng_status_t;

endpackage

FILE: hdl/lfu_pr_cmp.sv
module lfu_pr_cmp #(
    parameter int PAGE_BITS = 16,
    parameter int COUNT_BITS = 16,
    parameter int RANK_BITS = 3
) (
    input  logic                    cand_valid,
    input  logic [PAGE_BITS-1:0]    cand_page,
    input  logic [COUNT_BITS-1:0]   cand_count,
    input  logic [RANK_BITS-1:0]    cand_rank,
    input  logic [PAGE_BITS-1:0]    ref_page,
    input  logic                    hit_found,
    input  logic                    empty_found,
    input  logic                    vic_have,
    input  logic [COUNT_BITS-1:0]   vic_count,
    input  logic [RANK_BITS-1:0]    vic_rank,
    output lfu_pr_pkg::cmp_result_t result
);
    import lfu_pr_pkg::*;

    logic match;

    always_comb
    begin
        match = cand_valid && (cand_page == ref_page);
        result.take_hit = !hit_found && match;
        result.take_empty = !empty_found && !cand_valid;
        result.take_vic = !vic_have || (cand_count < vic_count) ||
                          ((cand_count == vic_count) && (cand_rank > vic_rank));
    end

endmodule

FILE: hdl/lfu_pr_engine.sv
module lfu_pr_engine #(
    parameter int FRAMES = 8,
    parameter int PAGE_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [PAGE_BITS-1:0]                    start_page,
    input  logic [lfu_pr_pkg::CFG_BITS-1:0]         frames_used,
    input  logic                                    commit,
    output lfu_pr_pkg::eng_status_t                 status,
    output logic [lfu_pr_pkg::FRAME_INDEX_BITS-1:0] slot_index,
    output logic [PAGE_BITS-1:0]                    old_page
);
    import lfu_pr_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] TOUCH_LAST = CNT_W'(FRAMES - 1);

    logic [PAGE_BITS-1:0]  page_mem [FRAMES];
    logic [COUNT_BITS-1:0] count_mem [FRAMES];
    logic [IDX_W-1:0]      rank_mem [FRAMES];

    logic [PAGE_BITS-1:0]  rd_page_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic [IDX_W-1:0]      rd_rank_reg;

    eng_state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic eval_reg, eval_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic [FRAMES-1:0] valid_reg;
    logic [PAGE_BITS-1:0] page_reg;

    logic hit_found_reg, empty_found_reg, vic_have_reg;
    logic [IDX_W-1:0] hit_idx_reg, empty_idx_reg, vic_idx_reg;
    logic [IDX_W-1:0] hit_rank_reg, vic_rank_reg;
    logic [COUNT_BITS-1:0] hit_count_reg, vic_count_reg;
    logic [PAGE_BITS-1:0] vic_page_reg;

    logic [CNT_W-1:0] n_active;
    logic [CNT_W-1:0] n_last;
    logic track_clear, track_en, pc_we, rk_we;
    cmp_result_t cmp;

    logic [IDX_W-1:0] sel_idx;
    logic [IDX_W-1:0] ref_rank;
    logic was_valid, evict;
    logic [COUNT_BITS-1:0] new_count;
    logic [IDX_W-1:0] rk_data;

    always_comb
    begin
        if (frames_used == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (int'(frames_used) > FRAMES)
        begin
            n_active = CNT_W'(FRAMES);
        end
        else
        begin
            n_active = CNT_W'(frames_used);
        end
        n_last = n_active - CNT_W'(1);
    end

    lfu_pr_cmp #(
        .PAGE_BITS(PAGE_BITS),
        .COUNT_BITS(COUNT_BITS),
        .RANK_BITS(IDX_W)
    ) u_cmp (
        .cand_valid(valid_reg[eval_idx_reg]),
        .cand_page(rd_page_reg),
        .cand_count(rd_count_reg),
        .cand_rank(rd_rank_reg),
        .ref_page(page_reg),
        .hit_found(hit_found_reg),
        .empty_found(empty_found_reg),
        .vic_have(vic_have_reg),
        .vic_count(vic_count_reg),
        .vic_rank(vic_rank_reg),
        .result(cmp)
    );

    always_comb
    begin
        if (hit_found_reg)
        begin
            sel_idx = hit_idx_reg;
            was_valid = 1'b1;
            ref_rank = hit_rank_reg;
            evict = 1'b0;
            new_count = (hit_count_reg == COUNT_MAX) ? hit_count_reg
                                                     : hit_count_reg + COUNT_BITS'(1);
        end
        else if (empty_found_reg)
        begin
            sel_idx = empty_idx_reg;
            was_valid = 1'b0;
            ref_rank = '0;
            evict = 1'b0;
            new_count = COUNT_BITS'(1);
        end
        else
        begin
            sel_idx = vic_idx_reg;
            was_valid = 1'b1;
            ref_rank = vic_rank_reg;
            evict = 1'b1;
            new_count = COUNT_BITS'(1);
        end

        if (eval_idx_reg == sel_idx)
        begin
            rk_data = '0;
        end
        else if (valid_reg[eval_idx_reg] && (!was_valid || (rd_rank_reg < ref_rank)))
        begin
            rk_data = rd_rank_reg + IDX_W'(1);
        end
        else
        begin
            rk_data = rd_rank_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        eval_next = 1'b0;
        eval_idx_next = idx_reg[IDX_W-1:0];
        track_clear = 1'b0;
        track_en = 1'b0;
        pc_we = 1'b0;
        rk_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    idx_next = '0;
                    track_clear = 1'b1;
                end
            end
            ST_SCAN:
            begin
                eval_next = 1'b1;
                track_en = eval_reg;
                if (idx_reg == n_last)
                begin
                    state_next = ST_SCAN_END;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_SCAN_END:
            begin
                track_en = eval_reg;
                state_next = ST_TOUCH;
            end
            ST_TOUCH:
            begin
                eval_next = 1'b1;
                rk_we = eval_reg;
                if (idx_reg == TOUCH_LAST)
                begin
                    state_next = ST_TOUCH_END;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_TOUCH_END:
            begin
                rk_we = eval_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (commit)
                begin
                    pc_we = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            eval_reg <= 1'b0;
            valid_reg <= '0;
            hit_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            vic_have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            eval_reg <= eval_next;
            if (pc_we)
            begin
                valid_reg[sel_idx] <= 1'b1;
            end
            if (track_clear)
            begin
                hit_found_reg <= 1'b0;
                empty_found_reg <= 1'b0;
                vic_have_reg <= 1'b0;
            end
            else if (track_en)
            begin
                if (cmp.take_hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (cmp.take_empty)
                begin
                    empty_found_reg <= 1'b1;
                end
                if (cmp.take_vic)
                begin
                    vic_have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        if (track_clear)
        begin
            page_reg <= start_page;
        end
        if (track_en)
        begin
            if (cmp.take_hit)
            begin
                hit_idx_reg <= eval_idx_reg;
                hit_rank_reg <= rd_rank_reg;
                hit_count_reg <= rd_count_reg;
            end
            if (cmp.take_empty)
            begin
                empty_idx_reg <= eval_idx_reg;
            end
            if (cmp.take_vic)
            begin
                vic_idx_reg <= eval_idx_reg;
                vic_rank_reg <= rd_rank_reg;
                vic_count_reg <= rd_count_reg;
                vic_page_reg <= rd_page_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pc_we)
        begin
            page_mem[sel_idx] <= page_reg;
            count_mem[sel_idx] <= new_count;
        end
        if (rk_we)
        begin
            rank_mem[eval_idx_reg] <= rk_data;
        end
        rd_page_reg <= page_mem[idx_reg[IDX_W-1:0]];
        rd_count_reg <= count_mem[idx_reg[IDX_W-1:0]];
        rd_rank_reg <= rank_mem[idx_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        status.idle = (state_reg == ST_IDLE);
        status.done = (state_reg == ST_WRITE);
        status.hit = hit_found_reg;
        status.evicted = evict;
        slot_index = FRAME_INDEX_BITS'(sel_idx);
        old_page = evict ? vic_page_reg : '0;
    end

endmodule

FILE: hdl/lfu_page_replacement.sv
// LFU page replacement with LRU tie-break among the lowest use counts.
// The request channel (req_valid, req_ready, page_number) carries one page
// reference per transfer. The response channel (rsp_valid, rsp_ready) returns
// one result per reference: hit, frame_index, evicted_valid, evicted_page and
// the saturating hit_total and miss_total counts.
// The user must write the frames_used register through cfg_we and cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Values of zero act as one and values above FRAMES as FRAMES. A result is
// ready after a scan of the frames in use and a rank pass over all frames,
// and the next reference can be taken in the cycle after the result is
// written. A scan reads one frame a cycle through the shared compare unit, and
// a second pass over all frames updates the recency ranks one frame a cycle.
// req_ready is high only while the block is idle, so one reference is in work
// at a time. A finished result sits in the output register while the next
// reference is taken; if the receiver still stalls when that one is done, the
// block holds it and stays busy until the response transfer frees the register.
// Reset empties all frames, clears both counts and sets frames_used to eight.
module lfu_page_replacement #(
    parameter int FRAMES = 8,
    parameter int PAGE_BITS = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [lfu_pr_pkg::CFG_BITS-1:0]         cfg_wdata,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  logic [PAGE_BITS-1:0]                    page_number,
    output logic                                    rsp_valid,
    input  logic                                    rsp_ready,
    output logic                                    hit,
    output logic [lfu_pr_pkg::FRAME_INDEX_BITS-1:0] frame_index,
    output logic                                    evicted_valid,
    output logic [PAGE_BITS-1:0]                    evicted_page,
    output logic [lfu_pr_pkg::CTR_BITS-1:0]         hit_total,
    output logic [lfu_pr_pkg::CTR_BITS-1:0]         miss_total
);
    import lfu_pr_pkg::*;

    logic [CFG_BITS-1:0] frames_used_reg;
    logic [CTR_BITS-1:0] hit_ctr_reg, hit_ctr_next;
    logic [CTR_BITS-1:0] miss_ctr_reg, miss_ctr_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic hit_reg;
    logic [FRAME_INDEX_BITS-1:0] frame_index_reg;
    logic evicted_valid_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;

    eng_status_t status;
    logic [FRAME_INDEX_BITS-1:0] slot_index;
    logic [PAGE_BITS-1:0] old_page;
    logic start, commit;

    assign start = req_valid && status.idle;
    assign commit = status.done && (!rsp_valid_reg || rsp_ready);

    lfu_pr_engine #(
        .FRAMES(FRAMES),
        .PAGE_BITS(PAGE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .start_page(page_number),
        .frames_used(frames_used_reg),
        .commit(commit),
        .status(status),
        .slot_index(slot_index),
        .old_page(old_page)
    );

    always_comb
    begin
        hit_ctr_next = hit_ctr_reg;
        miss_ctr_next = miss_ctr_reg;
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
            if (status.hit)
            begin
                if (hit_ctr_reg != '1)
                begin
                    hit_ctr_next = hit_ctr_reg + CTR_BITS'(1);
                end
            end
            else if (miss_ctr_reg != '1)
            begin
                miss_ctr_next = miss_ctr_reg + CTR_BITS'(1);
            end
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_used_reg <= FRAMES_USED_RESET;
            hit_ctr_reg <= '0;
            miss_ctr_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_used_reg <= cfg_wdata;
            end
            hit_ctr_reg <= hit_ctr_next;
            miss_ctr_reg <= miss_ctr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            hit_reg <= status.hit;
            frame_index_reg <= slot_index;
            evicted_valid_reg <= status.evicted;
            evicted_page_reg <= old_page;
        end
    end

    assign req_ready = status.idle;
    assign rsp_valid = rsp_valid_reg;
    assign hit = hit_reg;
    assign frame_index = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page = evicted_page_reg;
    assign hit_total = hit_ctr_reg;
    assign miss_total = miss_ctr_reg;

endmodule

FILE: hdl/lfu_pr_checker.sv
`include "lfu_page_replacement_defines.svh"

module lfu_pr_checker #(
    parameter int FRAMES = 8,
    parameter int PAGE_BITS = 16
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    req_valid,
    input logic                                    req_ready,
    input logic                                    rsp_valid,
    input logic                                    rsp_ready,
    input logic                                    hit,
    input logic [lfu_pr_pkg::FRAME_INDEX_BITS-1:0] frame_index,
    input logic                                    evicted_valid,
    input logic [PAGE_BITS-1:0]                    evicted_page,
    input logic [lfu_pr_pkg::CTR_BITS-1:0]         hit_total
);
    import lfu_pr_pkg::*;

    `LFU_ASSERT_IMPL(a_hit_no_evict, rsp_valid && hit, !evicted_valid)
    `LFU_ASSERT_IMPL(a_no_evict_zero_page, rsp_valid && !evicted_valid, evicted_page == '0)
    `LFU_ASSERT_IMPL(a_index_in_range, rsp_valid, int'(frame_index) < FRAMES)
    `LFU_ASSERT_NEXT(a_busy_after_request, req_valid && req_ready, !req_ready)
    `LFU_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(hit_total))

endmodule

bind lfu_page_replacement lfu_pr_checker #(
    .FRAMES(FRAMES),
    .PAGE_BITS(PAGE_BITS)
) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .hit(hit),
    .frame_index(frame_index),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .hit_total(hit_total)
);
